// File: design/rlps_pkg.sv
// ----------------------------------------------------------------------------
// rlps_pkg: shared types and constants of the LED pulse serializer
// Holds the queue entry types, the register indexes and the duration helper.
// ----------------------------------------------------------------------------
package rlps_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_ONE_HIGH    = 3'd0;
    localparam logic [2:0] CFG_ONE_LOW     = 3'd1;
    localparam logic [2:0] CFG_ZERO_HIGH   = 3'd2;
    localparam logic [2:0] CFG_ZERO_LOW    = 3'd3;
    localparam logic [2:0] CFG_RESET_TICKS = 3'd4;

    // Reset values of the timing registers.
    localparam logic [7:0]  ONE_HIGH_RST    = 8'd11;
    localparam logic [7:0]  ONE_LOW_RST     = 8'd9;
    localparam logic [7:0]  ZERO_HIGH_RST   = 8'd5;
    localparam logic [7:0]  ZERO_LOW_RST    = 8'd15;
    localparam logic [15:0] RESET_TICKS_RST = 16'd800;

    // Number of bits sent for one pixel.
    localparam logic [4:0] PIXEL_BITS = 5'd24;

    // One tick offered to the serializer, as held in the front queue.
    typedef struct packed {
        logic        pixel_valid;
        logic [23:0] pixel;
        logic        end_of_frame;
    } item_t;

    // One tick of output, as held in the result queue.
    typedef struct packed {
        logic line_level;
        logic pixel_taken;
        logic idle;
    } result_t;

    // A zero duration register counts as one tick.
    function automatic logic [15:0] stretch8(input logic [7:0] v);
        return (v == 8'd0) ? 16'd1 : {8'd0, v};
    endfunction

endpackage

// File: design/rgb_led_pulse_serializer.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer: LED data line pulse serializer
// Each transfer in is one tick of the line waveform; each transfer out gives
// the line level, whether the pixel was taken and whether the line was idle.
// ----------------------------------------------------------------------------
// Path: a tick accepted is held in the front queue, and its result is registered
// in the result queue, from which it can be taken; either queue can stall it.
// Throughput: one tick per cycle while the result queue is not full; the
// serializer state machine steps once per tick between the two two-entry queues.
// Reset: asynchronous, active low; queues empty, line idle, timing registers
// at their defaults (11, 9, 5, 15, 800).
module rgb_led_pulse_serializer
    import rlps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        pixel_valid,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic [7:0]  blue,
    input  logic        end_of_frame,
    output logic        empty,
    input  logic        pop,
    output logic        line_level,
    output logic        pixel_taken,
    output logic        idle,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t res;

    // Front: accepts and queues ticks.
    rlps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_valid  (pixel_valid),
        .green        (green),
        .red          (red),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    // Back: generates the waveform and queues results.
    rlps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign line_level  = res.line_level;
    assign pixel_taken = res.pixel_taken;
    assign idle        = res.idle;

endmodule

// File: design/rlps_front.sv
// ----------------------------------------------------------------------------
// rlps_front: input side of the LED pulse serializer
// Accepts ticks, packs the colour fields into one word and queues them in a
// two-entry buffer so that the serializer can stall on its own.
// ----------------------------------------------------------------------------
module rlps_front
    import rlps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        pixel_valid,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic [7:0]  blue,
    input  logic        end_of_frame,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push_ok;
    logic        pop_ok;
    item_t       packed_item;

    // Pack the tick: green in the top byte so it goes out first.
    always_comb
    begin
        packed_item.pixel_valid  = pixel_valid;
        packed_item.pixel        = {green, red, blue};
        packed_item.end_of_frame = end_of_frame;
    end

    assign full    = (count_reg == 2'd2);
    assign push_ok = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign pop_ok  = q_valid && q_ready;
    assign q_item  = slot_reg[rd_ptr_reg];

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= packed_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: design/rlps_engine.sv
// ----------------------------------------------------------------------------
// rlps_engine: pulse generator of the LED pulse serializer
// Steps the bit and gap state machine once per queued tick, holds the timing
// registers and buffers the per-tick results in a two-entry queue.
// ----------------------------------------------------------------------------
module rlps_engine
    import rlps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        empty,
    input  logic        pop,
    output result_t     res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    logic [7:0]  one_high_reg;
    logic [7:0]  one_low_reg;
    logic [7:0]  zero_high_reg;
    logic [7:0]  zero_low_reg;
    logic [15:0] reset_ticks_reg;

    phase_t      phase_reg, phase_next;
    logic [23:0] shift_reg, shift_next;
    logic [4:0]  bits_reg, bits_next;
    logic [15:0] tick_reg, tick_next;
    logic        gap_reg, gap_next;

    result_t     out_slot_reg [2];
    logic        out_wr_reg;
    logic        out_rd_reg;
    logic [1:0]  out_count_reg;

    logic        step;
    logic        out_pop;
    logic        start;
    phase_t      cur_phase;
    logic [23:0] cur_shift;
    logic [4:0]  cur_bits;
    logic [15:0] cur_tick;
    logic [15:0] tick_dec;
    logic [4:0]  bits_dec;
    logic [23:0] shift_adv;
    result_t     step_res;

    assign cfg_ready = 1'b1;
    assign q_ready   = (out_count_reg != 2'd2);
    assign step      = q_valid && q_ready;
    assign empty     = (out_count_reg == 2'd0);
    assign out_pop   = pop && !empty;
    assign res       = out_slot_reg[out_rd_reg];

    // Timing registers; a new value is used from the next phase that loads it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg    <= ONE_HIGH_RST;
            one_low_reg     <= ONE_LOW_RST;
            zero_high_reg   <= ZERO_HIGH_RST;
            zero_low_reg    <= ZERO_LOW_RST;
            reset_ticks_reg <= RESET_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ONE_HIGH:    one_high_reg    <= cfg_data[7:0];
                CFG_ONE_LOW:     one_low_reg     <= cfg_data[7:0];
                CFG_ZERO_HIGH:   zero_high_reg   <= cfg_data[7:0];
                CFG_ZERO_LOW:    zero_low_reg    <= cfg_data[7:0];
                CFG_RESET_TICKS: reset_ticks_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // One tick of the waveform: take a pixel if idle, then count down.
    always_comb
    begin
        start     = (phase_reg == PH_IDLE) && q_item.pixel_valid;
        cur_phase = start ? PH_HIGH : phase_reg;
        cur_shift = start ? q_item.pixel : shift_reg;
        cur_bits  = start ? PIXEL_BITS : bits_reg;
        if (start)
        begin
            cur_tick = q_item.pixel[23] ? stretch8(one_high_reg) : stretch8(zero_high_reg);
        end
        else
        begin
            cur_tick = tick_reg;
        end
        gap_next  = start ? q_item.end_of_frame : gap_reg;

        step_res.line_level  = (cur_phase == PH_HIGH);
        step_res.pixel_taken = start;
        step_res.idle        = (cur_phase == PH_IDLE);

        tick_dec  = (cur_tick != 16'd0) ? cur_tick - 16'd1 : 16'd0;
        bits_dec  = (cur_bits != 5'd0) ? cur_bits - 5'd1 : 5'd0;
        shift_adv = {cur_shift[22:0], 1'b0};

        phase_next = cur_phase;
        shift_next = cur_shift;
        bits_next  = cur_bits;
        tick_next  = cur_tick;

        if (cur_phase != PH_IDLE)
        begin
            tick_next = tick_dec;
            if (tick_dec == 16'd0)
            begin
                case (cur_phase)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        tick_next  = cur_shift[23] ? stretch8(one_low_reg)
                                                   : stretch8(zero_low_reg);
                    end
                    PH_LOW:
                    begin
                        shift_next = shift_adv;
                        bits_next  = bits_dec;
                        if (bits_dec != 5'd0)
                        begin
                            phase_next = PH_HIGH;
                            tick_next  = shift_adv[23] ? stretch8(one_high_reg)
                                                       : stretch8(zero_high_reg);
                        end
                        else if (gap_next)
                        begin
                            gap_next   = 1'b0;
                            phase_next = PH_GAP;
                            tick_next  = (reset_ticks_reg == 16'd0) ? 16'd1
                                                                    : reset_ticks_reg;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Serializer state, advanced once per queued tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            shift_reg <= 24'd0;
            bits_reg  <= 5'd0;
            tick_reg  <= 16'd0;
            gap_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            tick_reg  <= tick_next;
            gap_reg   <= gap_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_slot_reg[out_wr_reg] <= step_res;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            if (step)
            begin
                out_wr_reg <= ~out_wr_reg;
            end
            if (out_pop)
            begin
                out_rd_reg <= ~out_rd_reg;
            end
            if (step && !out_pop)
            begin
                out_count_reg <= out_count_reg + 2'd1;
            end
            else if (out_pop && !step)
            begin
                out_count_reg <= out_count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sim/rgb_led_pulse_serializer_checker.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer_checker: waveform predictor and result comparator
// Watches the tick, result and configuration channels of the serializer. It
// steps its own model of the line for every tick taken in, and compares each
// result taken out with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rgb_led_pulse_serializer_checker
    import rlps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        pixel_valid,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic [7:0]  blue,
    input  logic        end_of_frame,
    input  logic        empty,
    input  logic        pop,
    input  logic        line_level,
    input  logic        pixel_taken,
    input  logic        idle,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);

    typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_GAP} line_phase_t;

    // Timing registers as the predictor sees them.
    logic [7:0]  one_high_q;
    logic [7:0]  one_low_q;
    logic [7:0]  zero_high_q;
    logic [7:0]  zero_low_q;
    logic [15:0] latch_ticks_q;

    // Predicted serializer state.
    logic [23:0] colour_bits_q;
    logic [4:0]  bits_left_q;
    line_phase_t phase_q;
    logic [15:0] ticks_left_q;
    logic        latch_due_q;

    // Line results predicted but not yet taken out of the block.
    result_t expected_ticks[$];

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // High and low durations of the bit now at the top of the shift register.
    function automatic logic [15:0] high_ticks();
        return at_least_one({8'd0, colour_bits_q[23] ? one_high_q : zero_high_q});
    endfunction

    function automatic logic [15:0] low_ticks();
        return at_least_one({8'd0, colour_bits_q[23] ? one_low_q : zero_low_q});
    endfunction

    // Advance the line by one tick and give the output of that tick.
    task automatic advance_line(input logic offered, input logic [23:0] colour,
                                input logic frame_end, output result_t res);
        res = '0;
        if (phase_q == LINE_IDLE && offered)
        begin
            colour_bits_q = colour;
            bits_left_q = PIXEL_BITS;
            latch_due_q = frame_end;
            phase_q = LINE_HIGH;
            ticks_left_q = high_ticks();
            res.pixel_taken = 1'b1;
        end

        res.line_level = (phase_q == LINE_HIGH);
        res.idle = (phase_q == LINE_IDLE);

        if (phase_q != LINE_IDLE)
        begin
            if (ticks_left_q != 16'd0)
                ticks_left_q = ticks_left_q - 16'd1;
            if (ticks_left_q == 16'd0)
            begin
                case (phase_q)
                    LINE_HIGH:
                    begin
                        phase_q = LINE_LOW;
                        ticks_left_q = low_ticks();
                    end
                    LINE_LOW:
                    begin
                        colour_bits_q = colour_bits_q << 1;
                        if (bits_left_q != 5'd0)
                            bits_left_q = bits_left_q - 5'd1;
                        if (bits_left_q != 5'd0)
                        begin
                            phase_q = LINE_HIGH;
                            ticks_left_q = high_ticks();
                        end
                        else if (latch_due_q)
                        begin
                            latch_due_q = 1'b0;
                            phase_q = LINE_GAP;
                            ticks_left_q = at_least_one(latch_ticks_q);
                        end
                        else
                        begin
                            phase_q = LINE_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_q = LINE_IDLE;
                    end
                endcase
            end
        end
    endtask

    // Register writes, tick transfers in and result transfers out.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            one_high_q = ONE_HIGH_RST;
            one_low_q = ONE_LOW_RST;
            zero_high_q = ZERO_HIGH_RST;
            zero_low_q = ZERO_LOW_RST;
            latch_ticks_q = RESET_TICKS_RST;
            colour_bits_q = '0;
            bits_left_q = '0;
            phase_q = LINE_IDLE;
            ticks_left_q = '0;
            latch_due_q = 1'b0;
            expected_ticks.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ONE_HIGH:    one_high_q = cfg_data[7:0];
                    CFG_ONE_LOW:     one_low_q = cfg_data[7:0];
                    CFG_ZERO_HIGH:   zero_high_q = cfg_data[7:0];
                    CFG_ZERO_LOW:    zero_low_q = cfg_data[7:0];
                    CFG_RESET_TICKS: latch_ticks_q = cfg_data;
                    default:         ;
                endcase
            end

            if (push && !full)
            begin
                advance_line(pixel_valid, {green, red, blue}, end_of_frame, want);
                expected_ticks.push_back(want);
            end

            if (pop && !empty)
            begin
                got.line_level = line_level;
                got.pixel_taken = pixel_taken;
                got.idle = idle;
                if (expected_ticks.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: %b", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (got.line_level !== want.line_level)
                    begin
                        $display("%0t: line_level expected %b, got %b", $time,
                                 want.line_level, got.line_level);
                        fail_count++;
                    end
                    if (got.pixel_taken !== want.pixel_taken)
                    begin
                        $display("%0t: pixel_taken expected %b, got %b", $time,
                                 want.pixel_taken, got.pixel_taken);
                        fail_count++;
                    end
                    if (got.idle !== want.idle)
                    begin
                        $display("%0t: idle expected %b, got %b", $time,
                                 want.idle, got.idle);
                        fail_count++;
                    end
                end
            end

            outstanding = expected_ticks.size();
        end
    end

endmodule

// File: sim/tb_rgb_led_pulse_serializer.sv
// ----------------------------------------------------------------------------
// tb_rgb_led_pulse_serializer: testbench top of the LED pulse serializer
// Drives line ticks and timing register writes with random gaps and result
// stalls, and gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_rgb_led_pulse_serializer;
    import rlps_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 6;
    localparam int PHASE_TICKS  = 150;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        pixel_valid;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
    logic        end_of_frame;
    logic        empty;
    logic        pop;
    logic        line_level;
    logic        pixel_taken;
    logic        idle;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;

    // Stretch bookkeeping for the gaps of each side.
    int sender_left = 0;
    bit sender_calm = 1'b0;
    int drain_left = 0;
    bit drain_calm = 1'b0;

    rgb_led_pulse_serializer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_valid  (pixel_valid),
        .green        (green),
        .red          (red),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .empty        (empty),
        .pop          (pop),
        .line_level   (line_level),
        .pixel_taken  (pixel_taken),
        .idle         (idle),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rgb_led_pulse_serializer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_valid  (pixel_valid),
        .green        (green),
        .red          (red),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .empty        (empty),
        .pop          (pop),
        .line_level   (line_level),
        .pixel_taken  (pixel_taken),
        .idle         (idle),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A run that stops making progress ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgb_led_pulse_serializer: mismatch");
            $finish;
        end
    end

    // Cycles to wait before the next transfer: runs of busy and calm stretches.
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0)
        begin
            left = $urandom_range(10, 60);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Offer one line tick; entered and left at a falling edge.
    task automatic send_tick(input logic offered, input logic [7:0] g, input logic [7:0] r,
                             input logic [7:0] b, input logic frame_end);
        int gap;
        gap = draw_wait(sender_left, sender_calm);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        pixel_valid = offered;
        green = g;
        red = r;
        blue = b;
        end_of_frame = frame_end;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_tick();
        send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // Hold off until every predicted result has been taken and the block has settled.
    task automatic wait_drained();
        push = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Load all timing registers; the unused upper data bits carry noise.
    task automatic set_timing(input logic [7:0] oh, input logic [7:0] ol,
                              input logic [7:0] zh, input logic [7:0] zl,
                              input logic [15:0] gap_len);
        write_reg(CFG_ONE_HIGH, {8'($urandom_range(0, 255)), oh});
        write_reg(CFG_ONE_LOW, {8'($urandom_range(0, 255)), ol});
        write_reg(CFG_ZERO_HIGH, {8'($urandom_range(0, 255)), zh});
        write_reg(CFG_ZERO_LOW, {8'($urandom_range(0, 255)), zl});
        write_reg(CFG_RESET_TICKS, gap_len);
    endtask

    // Result side: pop with random stalls until the run ends.
    initial
    begin : result_drain
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(drain_left, drain_calm);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Tick side and verdict.
    initial
    begin : stimulus
        int phase_no;
        int k;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [15:0] gap_lo;
        logic [15:0] gap_hi;

        rst_n = 1'b0;
        push = 1'b0;
        pixel_valid = 1'b0;
        green = '0;
        red = '0;
        blue = '0;
        end_of_frame = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ONE_HIGH;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Reset timing: an end mark with no pixel, a pixel with the end mark,
        // then an offer while the line is busy.
        send_tick(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_tick(1'b1, 8'hFF, 8'h00, 8'h80, 1'b1);
        send_tick(1'b1, 8'h00, 8'hFF, 8'h7F, 1'b0);
        send_tick(1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_tick(1'b1, 8'h80, 8'h01, 8'hFE, 1'b1);
        wait_drained();

        // Zero durations act as one tick; the write lands mid-pixel. Writes to
        // unknown indexes must change nothing.
        set_timing(8'd0, 8'd1, 8'd1, 8'd0, 16'd0);
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd6, 16'h0001);
        write_reg(3'd7, 16'h8000);
        for (k = 0; k < 18; k++)
            send_tick(1'b1, 8'(k * 37), 8'hFF - 8'(k * 11), 8'(1 << (k % 8)), k[0]);

        // Random phases, each with its own timing.
        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            wait_drained();
            case (phase_no)
                1:       begin lo = 8'd0;   hi = 8'd4;   gap_lo = 16'd0;  gap_hi = 16'd4;  end
                3:       begin lo = 8'd1;   hi = 8'd6;   gap_lo = 16'd1;  gap_hi = 16'd20; end
                4:       begin lo = 8'd1;   hi = 8'd1;   gap_lo = 16'd1;  gap_hi = 16'd1;  end
                5:       begin lo = 8'd255; hi = 8'd255; gap_lo = 16'hFFFF; gap_hi = 16'hFFFF; end
                default: begin lo = 8'd1;   hi = 8'd3;   gap_lo = 16'd1;  gap_hi = 16'd6;  end
            endcase
            set_timing(8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
                       8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
                       16'($urandom_range(gap_lo, gap_hi)));
            for (k = 0; k < PHASE_TICKS; k++)
            begin
                // Once, let the result side catch up completely mid-phase.
                if (phase_no == 2 && k == PHASE_TICKS / 2)
                    wait_drained();
                random_tick();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("rgb_led_pulse_serializer: match");
        else
            $display("rgb_led_pulse_serializer: mismatch");
        $finish;
    end

endmodule
